@@ rtl/fpx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fpx_pkg;

    // Parse phases of one frame
    typedef enum logic [2:0] {
        PH_HDR_H = 3'd0,
        PH_HDR_L = 3'd1,
        PH_CMD   = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHK   = 3'd5
    } phase_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DROP    = 3'd0,
        ST_FIELD   = 3'd1,
        ST_PAYLOAD = 3'd2,
        ST_REQ_OK  = 3'd3,
        ST_RSP_OK  = 3'd4,
        ST_CHK_ERR = 3'd5
    } status_t;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_REQ_HI = 2'd0,
        REG_REQ_LO = 2'd1,
        REG_RSP_HI = 2'd2,
        REG_RSP_LO = 2'd3
    } cfg_reg_t;

    localparam logic [7:0] REQ_HI_RST = 8'hAA;
    localparam logic [7:0] REQ_LO_RST = 8'h55;
    localparam logic [7:0] RSP_HI_RST = 8'hA5;
    localparam logic [7:0] RSP_LO_RST = 8'h5A;

    // Header values seen by the parser
    typedef struct packed {
        logic [7:0] req_hi;
        logic [7:0] req_lo;
        logic [7:0] rsp_hi;
        logic [7:0] rsp_lo;
    } hdr_cfg_t;

    // One result request
    typedef struct packed {
        status_t    status;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] command;
        logic [7:0] frame_length;
        logic       rsp_frame;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/fpx_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fpx_cfg_regs (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output fpx_pkg::hdr_cfg_t      hdr_cfg
);

    fpx_pkg::hdr_cfg_t  cfg_reg;
    fpx_pkg::cfg_reg_t  reg_sel;
    logic               wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = fpx_pkg::cfg_reg_t'(paddr[3:2]);
    assign hdr_cfg = cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.req_hi <= fpx_pkg::REQ_HI_RST;
            cfg_reg.req_lo <= fpx_pkg::REQ_LO_RST;
            cfg_reg.rsp_hi <= fpx_pkg::RSP_HI_RST;
            cfg_reg.rsp_lo <= fpx_pkg::RSP_LO_RST;
        end else if (wr_en) begin
            case (reg_sel)
                fpx_pkg::REG_REQ_HI: cfg_reg.req_hi <= pwdata[7:0];
                fpx_pkg::REG_REQ_LO: cfg_reg.req_lo <= pwdata[7:0];
                fpx_pkg::REG_RSP_HI: cfg_reg.rsp_hi <= pwdata[7:0];
                fpx_pkg::REG_RSP_LO: cfg_reg.rsp_lo <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = 32'd0;
        case (reg_sel)
            fpx_pkg::REG_REQ_HI: prdata = {24'd0, cfg_reg.req_hi};
            fpx_pkg::REG_REQ_LO: prdata = {24'd0, cfg_reg.req_lo};
            fpx_pkg::REG_RSP_HI: prdata = {24'd0, cfg_reg.rsp_hi};
            fpx_pkg::REG_RSP_LO: prdata = {24'd0, cfg_reg.rsp_lo};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/fpx_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fpx_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic [7:0]        rx_byte,
    input  wire fpx_pkg::hdr_cfg_t hdr_cfg,
    output fpx_pkg::result_t       result
);

    fpx_pkg::phase_t phase_reg, phase_next;
    logic            resp_reg, resp_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [7:0]      len_reg, len_next;
    logic [7:0]      count_reg, count_next;
    logic [7:0]      xor_reg, xor_next;

    logic [7:0]      hdr_req;
    logic [7:0]      hdr_rsp;
    logic            req_hit;
    logic            rsp_hit;
    logic [7:0]      count_inc;

    // Header values for the current header phase
    assign hdr_req   = (phase_reg == fpx_pkg::PH_HDR_H) ? hdr_cfg.req_hi : hdr_cfg.req_lo;
    assign hdr_rsp   = (phase_reg == fpx_pkg::PH_HDR_H) ? hdr_cfg.rsp_hi : hdr_cfg.rsp_lo;
    assign req_hit   = (rx_byte == hdr_req);
    assign rsp_hit   = (rx_byte == hdr_rsp);
    assign count_inc = count_reg + 8'd1;

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fpx_pkg::PH_HDR_H;
            resp_reg  <= 1'b0;
            cmd_reg   <= 8'd0;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
            xor_reg   <= 8'd0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            resp_reg  <= resp_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            xor_reg   <= xor_next;
        end
    end

    // Next state and result for one byte
    always_comb begin
        phase_next           = phase_reg;
        resp_next            = resp_reg;
        cmd_next             = cmd_reg;
        len_next             = len_reg;
        count_next           = count_reg;
        xor_next             = xor_reg;
        result.status        = fpx_pkg::ST_DROP;
        result.payload_byte  = 8'd0;
        result.payload_index = 8'd0;
        result.command       = 8'd0;
        result.frame_length  = 8'd0;
        result.rsp_frame     = 1'b0;

        case (phase_reg)
            fpx_pkg::PH_HDR_H, fpx_pkg::PH_HDR_L: begin
                if (req_hit || rsp_hit) begin
                    // request kind wins when both match
                    resp_next     = !req_hit;
                    xor_next      = xor_reg ^ rx_byte;
                    phase_next    = (phase_reg == fpx_pkg::PH_HDR_H) ?
                                    fpx_pkg::PH_HDR_L : fpx_pkg::PH_CMD;
                    result.status = fpx_pkg::ST_FIELD;
                end else begin
                    phase_next = fpx_pkg::PH_HDR_H;
                    resp_next  = 1'b0;
                    cmd_next   = 8'd0;
                    len_next   = 8'd0;
                    count_next = 8'd0;
                    xor_next   = 8'd0;
                end
            end
            fpx_pkg::PH_CMD: begin
                cmd_next      = rx_byte;
                xor_next      = xor_reg ^ rx_byte;
                phase_next    = fpx_pkg::PH_LEN;
                result.status = fpx_pkg::ST_FIELD;
            end
            fpx_pkg::PH_LEN: begin
                len_next      = rx_byte;
                count_next    = 8'd0;
                xor_next      = xor_reg ^ rx_byte;
                // zero length skips the payload
                phase_next    = (rx_byte == 8'd0) ? fpx_pkg::PH_CHK : fpx_pkg::PH_DATA;
                result.status = fpx_pkg::ST_FIELD;
            end
            fpx_pkg::PH_DATA: begin
                result.payload_byte  = rx_byte;
                result.payload_index = count_reg;
                count_next           = count_inc;
                xor_next             = xor_reg ^ rx_byte;
                if (count_inc == len_reg) begin
                    phase_next = fpx_pkg::PH_CHK;
                end
                result.status        = fpx_pkg::ST_PAYLOAD;
            end
            fpx_pkg::PH_CHK: begin
                if (rx_byte == xor_reg) begin
                    result.status = resp_reg ? fpx_pkg::ST_RSP_OK : fpx_pkg::ST_REQ_OK;
                end else begin
                    result.status = fpx_pkg::ST_CHK_ERR;
                end
                phase_next = fpx_pkg::PH_HDR_H;
                resp_next  = 1'b0;
                cmd_next   = 8'd0;
                len_next   = 8'd0;
                count_next = 8'd0;
                xor_next   = 8'd0;
            end
            default: begin
                phase_next = fpx_pkg::PH_HDR_H;
                resp_next  = 1'b0;
                cmd_next   = 8'd0;
                len_next   = 8'd0;
                count_next = 8'd0;
                xor_next   = 8'd0;
            end
        endcase

        // frame end reports the frame just closed, else the updated fields
        if (phase_reg == fpx_pkg::PH_CHK) begin
            result.command      = cmd_reg;
            result.frame_length = len_reg;
            result.rsp_frame    = resp_reg;
        end else begin
            result.command      = cmd_next;
            result.frame_length = len_next;
            result.rsp_frame    = resp_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fpx_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fpx_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire fpx_pkg::result_t load_data,
    output logic                  can_load,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output fpx_pkg::result_t      m_data
);

    logic             valid_reg;
    fpx_pkg::result_t data_reg;

    // Slot is free when empty or draining this cycle
    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/framed_packet_parser_xor_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_rx_byte[7:0]
// m_        out        m_valid / m_ready    m_status[2:0], m_payload_byte[7:0],
//                                           m_payload_index[7:0], m_command[7:0],
//                                           m_frame_length[7:0], m_rsp_frame
// APB       in/out     psel/penable/pready  paddr[3:0], pwdata/prdata[31:0]
//
// One byte in, one result out; a new byte can be taken every cycle while m_ready lets results drain.
// Each byte passes the input register, then the parse logic into the result register.
// The parse state advances when a byte moves from the input register to the result register.
// Stalls on m_ready back up through the result register to s_ready without bubbles.
// Synchronous active-low reset clears the parser and both valid flags and loads the header reset values.

module framed_packet_parser_xor_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [7:0]       m_payload_byte,
    output logic [7:0]       m_payload_index,
    output logic [7:0]       m_command,
    output logic [7:0]       m_frame_length,
    output logic             m_rsp_frame,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              can_load;
    logic              advance;
    fpx_pkg::hdr_cfg_t hdr_cfg;
    fpx_pkg::result_t  step_result;
    fpx_pkg::result_t  out_data;

    assign advance = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    fpx_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .hdr_cfg (hdr_cfg)
    );

    fpx_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .hdr_cfg (hdr_cfg),
        .result  (step_result)
    );

    fpx_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .load_data (step_result),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_data)
    );

    assign m_status        = out_data.status;
    assign m_payload_byte  = out_data.payload_byte;
    assign m_payload_index = out_data.payload_index;
    assign m_command       = out_data.command;
    assign m_frame_length  = out_data.frame_length;
    assign m_rsp_frame     = out_data.rsp_frame;

    // Payload fields are zero outside payload results
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != fpx_pkg::ST_PAYLOAD)
        |-> (m_payload_byte == 8'd0) && (m_payload_index == 8'd0))
        else $error("payload fields set outside payload result");

    // A dropped byte leaves the parser fully restarted
    a_drop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == fpx_pkg::ST_DROP)
        |-> (m_command == 8'd0) && (m_frame_length == 8'd0) && !m_rsp_frame)
        else $error("dropped byte did not clear held frame fields");

    // Payload index stays inside the declared length
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == fpx_pkg::ST_PAYLOAD)
        |-> (m_payload_index < m_frame_length))
        else $error("payload index beyond frame length");

endmodule

`default_nettype wire

@@ sim/framed_packet_parser_xor_unit_tb.sv @@
`timescale 1ns / 1ps

module framed_packet_parser_xor_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;

    // Frame parser predictor and the results it still owes
    class frame_parse_tracker;
        logic [7:0]       hdr_val [4];
        fpx_pkg::phase_t  cur_phase;
        logic             rsp_flag;
        logic [7:0]       cmd_q;
        logic [7:0]       len_q;
        logic [7:0]       count_q;
        logic [7:0]       xor_q;
        fpx_pkg::result_t pending_results [$];
        int               mismatches;
        int               results_seen;
        int               status_count [6];

        function new();
            hdr_val[fpx_pkg::REG_REQ_HI] = fpx_pkg::REQ_HI_RST;
            hdr_val[fpx_pkg::REG_REQ_LO] = fpx_pkg::REQ_LO_RST;
            hdr_val[fpx_pkg::REG_RSP_HI] = fpx_pkg::RSP_HI_RST;
            hdr_val[fpx_pkg::REG_RSP_LO] = fpx_pkg::RSP_LO_RST;
            mismatches = 0;
            results_seen = 0;
            foreach (status_count[i]) status_count[i] = 0;
            restart();
        endfunction

        function void restart();
            cur_phase = fpx_pkg::PH_HDR_H;
            rsp_flag = 1'b0;
            cmd_q = 8'h00;
            len_q = 8'h00;
            count_q = 8'h00;
            xor_q = 8'h00;
        endfunction

        function void set_header(fpx_pkg::cfg_reg_t idx, logic [7:0] v);
            hdr_val[idx] = v;
        endfunction

        // Advance the parse state by one accepted byte
        function void note_rx_byte(logic [7:0] b);
            fpx_pkg::result_t r;
            logic [7:0]       req_val;
            logic [7:0]       rsp_val;
            logic             end_frame;
            r = '0;
            end_frame = 1'b0;
            case (cur_phase)
                fpx_pkg::PH_HDR_H, fpx_pkg::PH_HDR_L: begin
                    req_val = (cur_phase == fpx_pkg::PH_HDR_H) ?
                              hdr_val[fpx_pkg::REG_REQ_HI] : hdr_val[fpx_pkg::REG_REQ_LO];
                    rsp_val = (cur_phase == fpx_pkg::PH_HDR_H) ?
                              hdr_val[fpx_pkg::REG_RSP_HI] : hdr_val[fpx_pkg::REG_RSP_LO];
                    if (b == req_val || b == rsp_val) begin
                        // request kind wins when both values match
                        rsp_flag = (b != req_val);
                        xor_q ^= b;
                        cur_phase = (cur_phase == fpx_pkg::PH_HDR_H) ?
                                    fpx_pkg::PH_HDR_L : fpx_pkg::PH_CMD;
                        r.status = fpx_pkg::ST_FIELD;
                    end else begin
                        restart();
                        r.status = fpx_pkg::ST_DROP;
                    end
                end
                fpx_pkg::PH_CMD: begin
                    cmd_q = b;
                    xor_q ^= b;
                    cur_phase = fpx_pkg::PH_LEN;
                    r.status = fpx_pkg::ST_FIELD;
                end
                fpx_pkg::PH_LEN: begin
                    len_q = b;
                    count_q = 8'h00;
                    xor_q ^= b;
                    cur_phase = (b == 8'h00) ? fpx_pkg::PH_CHK : fpx_pkg::PH_DATA;
                    r.status = fpx_pkg::ST_FIELD;
                end
                fpx_pkg::PH_DATA: begin
                    r.payload_byte = b;
                    r.payload_index = count_q;
                    count_q = count_q + 8'd1;
                    xor_q ^= b;
                    if (count_q == len_q) cur_phase = fpx_pkg::PH_CHK;
                    r.status = fpx_pkg::ST_PAYLOAD;
                end
                fpx_pkg::PH_CHK: begin
                    if (b == xor_q) r.status = rsp_flag ? fpx_pkg::ST_RSP_OK : fpx_pkg::ST_REQ_OK;
                    else r.status = fpx_pkg::ST_CHK_ERR;
                    end_frame = 1'b1;
                end
                default: begin
                    restart();
                    r.status = fpx_pkg::ST_DROP;
                end
            endcase
            // held fields reflect the frame just ended on the checksum byte
            r.command = cmd_q;
            r.frame_length = len_q;
            r.rsp_frame = rsp_flag;
            if (end_frame) restart();
            pending_results.push_back(r);
        endfunction

        // Compare one result against the oldest prediction
        function void check_result(fpx_pkg::result_t got);
            fpx_pkg::result_t want;
            logic             bad;
            results_seen++;
            if (got.status <= fpx_pkg::ST_CHK_ERR) status_count[int'(got.status)]++;
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: st=%0d pb=%02h pi=%0d cmd=%02h len=%0d rsp=%0b",
                             got.status, got.payload_byte, got.payload_index, got.command,
                             got.frame_length, got.rsp_frame);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            bad = (got.status !== want.status) || (got.payload_byte !== want.payload_byte) ||
                  (got.payload_index !== want.payload_index) ||
                  (got.command !== want.command) ||
                  (got.frame_length !== want.frame_length) ||
                  (got.rsp_frame !== want.rsp_frame);
            if (bad) begin
                if (mismatches < 10) begin
                    $display("result %0d mismatch at %0t", results_seen, $realtime);
                    $display("  expected st=%0d pb=%02h pi=%0d cmd=%02h len=%0d rsp=%0b",
                             want.status, want.payload_byte, want.payload_index, want.command,
                             want.frame_length, want.rsp_frame);
                    $display("  actual   st=%0d pb=%02h pi=%0d cmd=%02h len=%0d rsp=%0b",
                             got.status, got.payload_byte, got.payload_index, got.command,
                             got.frame_length, got.rsp_frame);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_payload_index;
    logic [7:0]  m_command;
    logic [7:0]  m_frame_length;
    logic        m_rsp_frame;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_parse_tracker tracker;
    logic [7:0] hdr_now [4];
    int send_idle_pct;
    int stall_pct;
    int rx_hold_len;
    int bytes_sent;
    int header_sets;
    int quiet_cycles;

    framed_packet_parser_xor_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_command       (m_command),
        .m_frame_length  (m_frame_length),
        .m_rsp_frame     (m_rsp_frame),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Monitor: predict on accepted bytes, check accepted results
    always @(posedge aclk) begin : monitor
        fpx_pkg::result_t got;
        if (aresetn) begin
            if (s_valid && s_ready) tracker.note_rx_byte(s_rx_byte);
            if (m_valid && m_ready) begin
                got.status = fpx_pkg::status_t'(m_status);
                got.payload_byte = m_payload_byte;
                got.payload_index = m_payload_index;
                got.command = m_command;
                got.frame_length = m_frame_length;
                got.rsp_frame = m_rsp_frame;
                tracker.check_result(got);
            end
        end
    end

    // Watchdog on cycles with no handshake of any kind
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pwrite && pready))
            quiet_cycles = 0;
        else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("[framed_packet_parser_xor_unit] ERROR");
                $finish;
            end
        end
    end

    // Result side: random stalls, or a long hold-off when requested
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_len != 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_len) @(posedge aclk);
                rx_hold_len = 0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one byte and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    // Build a frame from the current header values; keep limits how many bytes go out
    task automatic send_frame(input bit hi_rsp, input bit lo_rsp, input logic [7:0] cmd,
                              input int len, input bit bad_chk, input int keep);
        logic [7:0] frame_bytes [$];
        logic [7:0] sum;
        frame_bytes.push_back(hi_rsp ? hdr_now[fpx_pkg::REG_RSP_HI] : hdr_now[fpx_pkg::REG_REQ_HI]);
        frame_bytes.push_back(lo_rsp ? hdr_now[fpx_pkg::REG_RSP_LO] : hdr_now[fpx_pkg::REG_REQ_LO]);
        frame_bytes.push_back(cmd);
        frame_bytes.push_back(8'(len));
        repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
        sum = 8'h00;
        foreach (frame_bytes[i]) sum ^= frame_bytes[i];
        if (bad_chk) sum ^= 8'h01 << $urandom_range(7);
        frame_bytes.push_back(sum);
        foreach (frame_bytes[i])
            if (i < keep) send_byte(frame_bytes[i]);
    endtask

    // APB write: setup then access, then psel, penable and pwrite return low
    task automatic write_header(input fpx_pkg::cfg_reg_t idx, input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'h0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.set_header(idx, v);
        hdr_now[idx] = v;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (tracker.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_headers(input logic [7:0] rq_hi, input logic [7:0] rq_lo,
                               input logic [7:0] rs_hi, input logic [7:0] rs_lo);
        s_valid <= 1'b0;
        wait_drained();
        write_header(fpx_pkg::REG_REQ_HI, rq_hi);
        write_header(fpx_pkg::REG_REQ_LO, rq_lo);
        write_header(fpx_pkg::REG_RSP_HI, rs_hi);
        write_header(fpx_pkg::REG_RSP_LO, rs_lo);
        header_sets++;
    endtask

    // Mostly well-formed frames, the rest noise and broken frames
    task automatic run_phase(input int idle_pct, input int stall, input int n_bytes);
        int stop_at;
        int pick;
        int len;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            if (pick < 70)
                send_frame(1'($urandom_range(1)), 1'($urandom_range(1)),
                           8'($urandom_range(255)), len, $urandom_range(9) == 0, 1000);
            else if (pick < 80)
                send_byte(8'($urandom_range(255)));
            else if (pick < 88) begin
                send_frame(1'($urandom_range(1)), 1'b0, 8'h00, 0, 1'b0, 1);
                send_byte(8'($urandom_range(255)));
            end else if (pick < 94)
                send_frame(1'($urandom_range(1)), 1'($urandom_range(1)),
                           8'($urandom_range(255)), len, 1'b1, 1000);
            else
                send_frame(1'($urandom_range(1)), 1'($urandom_range(1)),
                           8'($urandom_range(255)), len, 1'b0, $urandom_range(1, len + 4));
        end
    endtask

    // Main sequence
    initial begin
        tracker = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'h00;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        rx_hold_len = 0;
        bytes_sent = 0;
        header_sets = 0;
        quiet_cycles = 0;
        hdr_now[fpx_pkg::REG_REQ_HI] = fpx_pkg::REQ_HI_RST;
        hdr_now[fpx_pkg::REG_REQ_LO] = fpx_pkg::REQ_LO_RST;
        hdr_now[fpx_pkg::REG_RSP_HI] = fpx_pkg::RSP_HI_RST;
        hdr_now[fpx_pkg::REG_RSP_LO] = fpx_pkg::RSP_LO_RST;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero length, response frame, drops, bad checksum, mixed header
        send_frame(1'b0, 1'b0, 8'h00, 0, 1'b0, 1000);
        send_frame(1'b1, 1'b1, 8'hFF, 1, 1'b0, 1000);
        send_byte(8'h00);
        send_frame(1'b0, 1'b0, 8'h00, 0, 1'b0, 1);
        send_byte(8'h00);
        send_frame(1'b0, 1'b0, 8'h3C, 0, 1'b1, 1000);
        send_frame(1'b1, 1'b0, 8'h81, 2, 1'b0, 1000);

        // Reset headers, full-size frame, no idling
        run_phase(0, 0, 40);
        send_frame(1'b1, 1'b1, 8'h5A, 255, 1'b0, 1000);

        // Equal request and response headers at the extremes
        set_headers(8'h00, 8'hFF, 8'h00, 8'hFF);
        run_phase(75, 0, 40);

        // Opposite extremes; long result hold-off so the input backs up
        set_headers(8'hFF, 8'h00, 8'h00, 8'hFF);
        rx_hold_len = 300;
        run_phase(0, 75, 40);

        // Random header values, light idling on both sides
        set_headers(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)));
        run_phase(8, 8, 40);

        // Back to reset values
        set_headers(fpx_pkg::REQ_HI_RST, fpx_pkg::REQ_LO_RST,
                    fpx_pkg::RSP_HI_RST, fpx_pkg::RSP_LO_RST);
        run_phase(0, 0, 40);

        s_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);

        $display("covered %0d bytes under %0d header settings, %0d results checked",
                 bytes_sent, header_sets + 1, tracker.results_seen);
        $display("  payload %0d, request ok %0d, response ok %0d, bad checksum %0d, dropped %0d",
                 tracker.status_count[fpx_pkg::ST_PAYLOAD],
                 tracker.status_count[fpx_pkg::ST_REQ_OK],
                 tracker.status_count[fpx_pkg::ST_RSP_OK],
                 tracker.status_count[fpx_pkg::ST_CHK_ERR],
                 tracker.status_count[fpx_pkg::ST_DROP]);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("[framed_packet_parser_xor_unit] OK");
        end else begin
            $display("%0d mismatches", tracker.mismatches);
            $display("[framed_packet_parser_xor_unit] ERROR");
        end
        $finish;
    end

endmodule
